### hdl/pbc_pkg.sv
// Package: widths, limits and the cents-to-ratio table for the pitch bend block.
package pbc_pkg;

  localparam int unsigned FreqW      = 32;
  localparam int unsigned BendW      = 13;
  localparam int unsigned RatioW     = 25;
  localparam int unsigned RatioFrac  = 24;
  localparam int unsigned AccW       = 34;
  localparam int unsigned RomDepth   = 201;
  localparam int unsigned RomAddrW   = 8;

  localparam logic signed [BendW-1:0] MaxBendCents = 13'sd2400;
  localparam logic signed [BendW-1:0] CentsPerStep = 13'sd100;

  typedef logic [FreqW-1:0]    freq_t;
  typedef logic signed [BendW-1:0] bend_t;
  typedef logic [RatioW-1:0]   ratio_t;
  typedef logic [AccW-1:0]     acc_t;
  typedef logic [RomAddrW-1:0] rom_addr_t;

  // UQ1.24 ratios 2^(c/1200), c = -100..+100
  localparam ratio_t RatioRom [RomDepth] = '{
    25'h0f1a1bf, 25'h0f1c57d, 25'h0f1e940, 25'h0f20d08, 25'h0f230d5, 25'h0f254a8, 25'h0f27880,
    25'h0f29c5e, 25'h0f2c040, 25'h0f2e428, 25'h0f30816, 25'h0f32c08, 25'h0f35000, 25'h0f373fe,
    25'h0f39800, 25'h0f3bc08, 25'h0f3e015, 25'h0f40428, 25'h0f42840, 25'h0f44c5d, 25'h0f47080,
    25'h0f494a8, 25'h0f4b8d5, 25'h0f4dd08, 25'h0f50140, 25'h0f5257d, 25'h0f549c0, 25'h0f56e08,
    25'h0f59255, 25'h0f5b6a8, 25'h0f5db00, 25'h0f5ff5e, 25'h0f623c1, 25'h0f64829, 25'h0f66c97,
    25'h0f6910a, 25'h0f6b582, 25'h0f6da00, 25'h0f6fe84, 25'h0f7230c, 25'h0f7479a, 25'h0f76c2e,
    25'h0f790c7, 25'h0f7b565, 25'h0f7da09, 25'h0f7feb2, 25'h0f82361, 25'h0f84815, 25'h0f86cce,
    25'h0f8918d, 25'h0f8b651, 25'h0f8db1b, 25'h0f8ffea, 25'h0f924bf, 25'h0f94999, 25'h0f96e78,
    25'h0f9935d, 25'h0f9b848, 25'h0f9dd38, 25'h0fa022d, 25'h0fa2728, 25'h0fa4c28, 25'h0fa712e,
    25'h0fa9639, 25'h0fabb4a, 25'h0fae060, 25'h0fb057c, 25'h0fb2a9d, 25'h0fb4fc4, 25'h0fb74f0,
    25'h0fb9a21, 25'h0fbbf59, 25'h0fbe495, 25'h0fc09d7, 25'h0fc2f1f, 25'h0fc546c, 25'h0fc79bf,
    25'h0fc9f17, 25'h0fcc475, 25'h0fce9d8, 25'h0fd0f41, 25'h0fd34b0, 25'h0fd5a23, 25'h0fd7f9d,
    25'h0fda51c, 25'h0fdcaa0, 25'h0fdf02a, 25'h0fe15ba, 25'h0fe3b4f, 25'h0fe60ea, 25'h0fe868a,
    25'h0feac30, 25'h0fed1dc, 25'h0fef78d, 25'h0ff1d43, 25'h0ff42ff, 25'h0ff68c1, 25'h0ff8e88,
    25'h0ffb455, 25'h0ffda28, 25'h1000000, 25'h10025de, 25'h1004bc1, 25'h10071aa, 25'h1009798,
    25'h100bd8d, 25'h100e386, 25'h1010986, 25'h1012f8b, 25'h1015595, 25'h1017ba5, 25'h101a1bb,
    25'h101c7d7, 25'h101edf8, 25'h102141f, 25'h1023a4b, 25'h102607d, 25'h10286b5, 25'h102acf2,
    25'h102d335, 25'h102f97e, 25'h1031fcc, 25'h1034620, 25'h1036c7a, 25'h10392d9, 25'h103b93e,
    25'h103dfa9, 25'h1040619, 25'h1042c8f, 25'h104530b, 25'h104798d, 25'h104a014, 25'h104c6a1,
    25'h104ed33, 25'h10513cb, 25'h1053a69, 25'h105610d, 25'h10587b6, 25'h105ae65, 25'h105d51a,
    25'h105fbd5, 25'h1062295, 25'h106495b, 25'h1067027, 25'h10696f8, 25'h106bdd0, 25'h106e4ad,
    25'h1070b8f, 25'h1073278, 25'h1075966, 25'h107805a, 25'h107a754, 25'h107ce53, 25'h107f558,
    25'h1081c64, 25'h1084374, 25'h1086a8b, 25'h10891a7, 25'h108b8ca, 25'h108dff1, 25'h109071f,
    25'h1092e53, 25'h109558c, 25'h1097ccb, 25'h109a410, 25'h109cb5b, 25'h109f2ac, 25'h10a1a02,
    25'h10a415e, 25'h10a68c0, 25'h10a9028, 25'h10ab796, 25'h10adf09, 25'h10b0683, 25'h10b2e02,
    25'h10b5587, 25'h10b7d12, 25'h10ba4a2, 25'h10bcc39, 25'h10bf3d5, 25'h10c1b78, 25'h10c4320,
    25'h10c6ace, 25'h10c9282, 25'h10cba3c, 25'h10ce1fb, 25'h10d09c1, 25'h10d318c, 25'h10d595d,
    25'h10d8135, 25'h10da912, 25'h10dd0f5, 25'h10df8dd, 25'h10e20cc, 25'h10e48c1, 25'h10e70bb,
    25'h10e98bc, 25'h10ec0c2, 25'h10ee8cf, 25'h10f10e1, 25'h10f38f9
  };

endpackage

### hdl/pbc_in_if.sv
// Interface: input channel carrying frequency and bend.
interface pbc_in_if;
  logic                 valid;
  logic                 ready;
  pbc_pkg::freq_t       base_freq;
  pbc_pkg::bend_t       bend_cents;

  modport source (output valid, output base_freq, output bend_cents, input ready);
  modport sink   (input valid, input base_freq, input bend_cents, output ready);
endinterface

### hdl/pbc_out_if.sv
// Interface: output channel carrying the bent frequency.
interface pbc_out_if;
  logic           valid;
  logic           ready;
  pbc_pkg::freq_t bent_freq;

  modport source (output valid, output bent_freq, input ready);
  modport sink   (input valid, input bent_freq, output ready);
endinterface

### hdl/pitch_bend_by_cents.sv
// Top level: pitch bend of a UQ16.16 frequency by a signed number of cents.
//
// Channels: in_i (sink) takes base_freq (UQ16.16) and bend_cents (signed);
// out_o (source) returns bent_freq (UQ16.16), one result per input transfer.
// Valid/ready handshake on both; a transfer happens when both are high.
//
// Work: the bend is clamped to +/-2400 cents. Whole-semitone steps multiply
// the accumulator by the +/-100 cent ROM entry and shift right by 24, one
// step per cycle; a last multiply uses the entry for the remaining cents.
// The ratio ROM has a registered read, so a fresh address costs a wait
// state in ST_LOAD (at the start, and again before the fine multiply after steps).
//
// Sequence after an input transfer: ST_LOAD, ST_MUL, ST_DONE when no
// semitone step is needed, else ST_LOAD, n ST_MUL steps (1..23), then
// ST_LOAD, the fine ST_MUL and ST_DONE. One item is in flight at a time;
// the next input is taken as soon as the result has been moved into the
// output register, even while it waits for the receiver.
// A stalled receiver holds the result and, after that, holds the sequencer.
// Reset clears the sequencer and the output valid; no clearing pass.
module pitch_bend_by_cents (
  input  logic       clk_i,
  input  logic       rst_ni,
  pbc_in_if.sink     in_i,
  pbc_out_if.source  out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DONE
  } state_e;

  state_e              state_q;
  pbc_pkg::acc_t       acc_q;
  pbc_pkg::bend_t      bend_q;
  logic                fine_q;
  logic                out_valid_q;
  pbc_pkg::freq_t      out_data_q;

  pbc_pkg::rom_addr_t  rom_addr;
  pbc_pkg::ratio_t     rom_data;
  pbc_pkg::bend_t      bend_clamp;
  pbc_pkg::bend_t      bend_next;
  pbc_pkg::bend_t      bend_idx;
  logic [pbc_pkg::AccW+pbc_pkg::RatioW-1:0] prod;
  pbc_pkg::acc_t       acc_next;
  logic                out_load;

  // Clamp incoming bend
  always_comb begin
    bend_clamp = in_i.bend_cents;
    if (in_i.bend_cents > pbc_pkg::MaxBendCents) begin
      bend_clamp = pbc_pkg::MaxBendCents;
    end else if (in_i.bend_cents < -pbc_pkg::MaxBendCents) begin
      bend_clamp = -pbc_pkg::MaxBendCents;
    end
  end

  // ROM address follows the current bend: table ends for semitone steps
  always_comb begin
    if (bend_q < -pbc_pkg::CentsPerStep) begin
      bend_idx = -pbc_pkg::CentsPerStep;
    end else if (bend_q > pbc_pkg::CentsPerStep) begin
      bend_idx = pbc_pkg::CentsPerStep;
    end else begin
      bend_idx = bend_q;
    end
    bend_next = bend_q - bend_idx;
  end

  assign rom_addr = pbc_pkg::rom_addr_t'(bend_idx + pbc_pkg::CentsPerStep);

  pbc_ratio_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // 34x25 multiply, then drop the 24 fraction bits
  assign prod     = {{pbc_pkg::RatioW{1'b0}}, acc_q} * {{pbc_pkg::AccW{1'b0}}, rom_data};
  assign acc_next = prod[pbc_pkg::RatioFrac +: pbc_pkg::AccW];

  // Result moves into the output register when it is free or being drained
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.bent_freq = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      fine_q      <= 1'b0;
      acc_q       <= '0;
      bend_q      <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= acc_q[pbc_pkg::FreqW-1:0];
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            acc_q   <= pbc_pkg::acc_t'(in_i.base_freq);
            bend_q  <= bend_clamp;
            fine_q  <= (bend_clamp >= -pbc_pkg::CentsPerStep) &&
                       (bend_clamp <= pbc_pkg::CentsPerStep);
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          acc_q  <= acc_next;
          bend_q <= bend_next;
          if (fine_q) begin
            state_q <= ST_DONE;
          end else if ((bend_next >= -pbc_pkg::CentsPerStep) &&
                       (bend_next <= pbc_pkg::CentsPerStep)) begin
            fine_q  <= 1'b1;
            state_q <= ST_LOAD;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/pbc_ratio_rom.sv
// Ratio ROM with registered read.
module pbc_ratio_rom (
  input  logic                clk_i,
  input  pbc_pkg::rom_addr_t  addr_i,
  output pbc_pkg::ratio_t     data_o
);

  pbc_pkg::ratio_t data_q;

  always_ff @(posedge clk_i) begin
    data_q <= pbc_pkg::RatioRom[addr_i];
  end

  assign data_o = data_q;

endmodule
